@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define MME_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MME_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mme_pkg.sv @@
// shared types, constants and helpers for the matrix multiply engine
// no dependencies
`timescale 1ns / 1ps

package mme_pkg;

  // default sizes for the top level parameters
  localparam int MaxDimDef    = 8;
  localparam int ElemWidthDef = 16;

  // fixed field widths
  localparam int DimW    = 4;
  localparam int CfgIdxW = 2;
  localparam int IdxW    = 3;
  localparam int ValW    = 35;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRowsA    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInnerDim = 2'd1;
  localparam logic [CfgIdxW-1:0] RegColsB    = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } mme_state_e;

  // clamp a dimension register to 1..max_d
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] r, logic [DimW-1:0] max_d);
    logic [DimW-1:0] d;
    d = r;
    if (d == '0) d = {{(DimW-1){1'b0}}, 1'b1};
    if (d > max_d) d = max_d;
    return d;
  endfunction

endpackage

@@ hdl/mme_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mme_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/matrix_multiply_engine_unit.sv @@
// Dense fixed-point matrix multiply C = A x B with A and B held in two small RAMs.
// Each input transaction carries one signed element for store A or B; a transaction
// with start_multiply set then makes the block compute C element by element in
// row-major order on one shared multiply-accumulate unit. Each element of C is
// built from inner_dim reads of one pair per cycle (one read port per store), which
// pass the RAM read register and the product register, and the sum is handed to
// the output register. A start transaction keeps the input not ready until the
// last element of C is taken into the output register, so result side stalls
// lengthen it. Elements outside the configured shape are dropped; reading
// a never written entry gives undefined data. Depends on mme_pkg and mme_ram.
`timescale 1ns / 1ps

module matrix_multiply_engine_unit #(
  parameter int MAX_DIM    = mme_pkg::MaxDimDef,
  parameter int ELEM_WIDTH = mme_pkg::ElemWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mme_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mme_pkg::DimW-1:0]         cfg_data_i,
  // element input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             matrix_select_i,
  input  logic [mme_pkg::IdxW-1:0]         row_index_i,
  input  logic [mme_pkg::IdxW-1:0]         col_index_i,
  input  logic signed [15:0]               element_value_i,
  input  logic                             start_multiply_i,
  // result output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mme_pkg::IdxW-1:0]         out_row_o,
  output logic [mme_pkg::IdxW-1:0]         out_col_o,
  output logic signed [mme_pkg::ValW-1:0]  out_value_o,
  output logic                             last_result_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ProdW = 2 * ELEM_WIDTH;
  localparam int DW    = mme_pkg::DimW;
  localparam int VW    = mme_pkg::ValW;

  // configuration registers
  logic [DW-1:0] rows_a_q, inner_dim_q, cols_b_q;

  // effective shape
  logic [DW-1:0] dim_m, dim_k, dim_n;

  // sequencer
  mme_pkg::mme_state_e state_q, state_d;
  logic start_run, issue, emit;

  // loop counters
  logic [CntW-1:0] i_q, j_q, t_q;
  logic            t_last, i_last, j_last;

  // pipeline control
  logic rd_vld_q, rd_last_q, mul_vld_q, mul_last_q;

  // datapath
  logic [ELEM_WIDTH-1:0]   a_rdata, b_rdata;
  logic signed [ProdW-1:0] prod_q;
  logic signed [VW-1:0]    acc_q;

  // store writes
  logic             a_we, b_we;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;
  logic             in_fire;

  // output register
  logic                 out_valid_q, out_last_q;
  logic [CntW-1:0]      out_row_q, out_col_q;
  logic signed [VW-1:0] out_value_q;

  assign cfg_ready_o = 1'b1;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DW'(8);
      inner_dim_q <= DW'(8);
      cols_b_q    <= DW'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mme_pkg::RegRowsA:    rows_a_q    <= cfg_data_i;
        mme_pkg::RegInnerDim: inner_dim_q <= cfg_data_i;
        mme_pkg::RegColsB:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp shape to 1..MAX_DIM
  assign dim_m = mme_pkg::eff_dim(rows_a_q, DW'(MAX_DIM));
  assign dim_k = mme_pkg::eff_dim(inner_dim_q, DW'(MAX_DIM));
  assign dim_n = mme_pkg::eff_dim(cols_b_q, DW'(MAX_DIM));

  // element store with shape check
  assign in_fire = in_valid_i && in_ready_o;
  assign waddr   = AddrW'(int'(row_index_i) * MAX_DIM + int'(col_index_i));
  assign a_we    = in_fire && !matrix_select_i &&
                   (DW'(row_index_i) < dim_m) && (DW'(col_index_i) < dim_k);
  assign b_we    = in_fire && matrix_select_i &&
                   (DW'(row_index_i) < dim_k) && (DW'(col_index_i) < dim_n);

  // read addresses for the current term
  assign a_raddr = AddrW'(int'(i_q) * MAX_DIM + int'(t_q));
  assign b_raddr = AddrW'(int'(t_q) * MAX_DIM + int'(j_q));

  mme_ram #(
    .Width (ELEM_WIDTH),
    .Depth (Depth)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (element_value_i[ELEM_WIDTH-1:0]),
    .re_i    (issue),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(
    .Width (ELEM_WIDTH),
    .Depth (Depth)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (element_value_i[ELEM_WIDTH-1:0]),
    .re_i    (issue),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // loop end detection
  assign t_last = (DW'(t_q) == dim_k - DW'(1));
  assign i_last = (DW'(i_q) == dim_m - DW'(1));
  assign j_last = (DW'(j_q) == dim_n - DW'(1));

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mme_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    start_run  = 1'b0;
    issue      = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      mme_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && start_multiply_i) begin
          start_run = 1'b1;
          state_d   = mme_pkg::S_MAC;
        end
      end
      mme_pkg::S_MAC: begin
        issue = 1'b1;
        if (t_last) state_d = mme_pkg::S_DRAIN;
      end
      mme_pkg::S_DRAIN: begin
        if (mul_vld_q && mul_last_q) state_d = mme_pkg::S_EMIT;
      end
      mme_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = (i_last && j_last) ? mme_pkg::S_IDLE : mme_pkg::S_MAC;
        end
      end
      default: state_d = mme_pkg::S_IDLE;
    endcase
  end

  // counters, pipeline flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      t_q         <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q   <= issue;
      rd_last_q  <= issue && t_last;
      mul_vld_q  <= rd_vld_q;
      mul_last_q <= rd_last_q;
      if (start_run) begin
        i_q <= '0;
        j_q <= '0;
        t_q <= '0;
      end else if (issue) begin
        t_q <= t_last ? '0 : t_q + CntW'(1);
      end else if (emit) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + CntW'(1);
        end else begin
          j_q <= j_q + CntW'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared multiply-accumulate unit and result payload
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'($signed(a_rdata)) * ProdW'($signed(b_rdata));
    if (start_run || emit) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + VW'(prod_q);
    end
    if (emit) begin
      out_row_q   <= i_q;
      out_col_q   <= j_q;
      out_value_q <= acc_q;
      out_last_q  <= i_last && j_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = mme_pkg::IdxW'(out_row_q);
  assign out_col_o     = mme_pkg::IdxW'(out_col_q);
  assign out_value_o   = out_value_q;
  assign last_result_o = out_last_q;

endmodule

@@ hdl/mme_checker.sv @@
// port-level checker for the matrix multiply engine, bound to the top level
// depends on mme_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mme_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             start_multiply_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [mme_pkg::IdxW-1:0]         out_row_o,
  input logic [mme_pkg::IdxW-1:0]         out_col_o,
  input logic signed [mme_pkg::ValW-1:0]  out_value_o,
  input logic                             last_result_o
);

  // a stalled result stays offered
  `MME_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // a stalled result keeps its value
  `MME_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_value_o) && $stable(last_result_o) && $stable(out_row_o) && $stable(out_col_o), "result changed while stalled")

  // a plain store transaction leaves the input ready
  `MME_ASSERT(a_store_ready, clk_i, rst_ni, in_valid_i && in_ready_o && !start_multiply_i |=> in_ready_o, "input not ready after a store")

  // a start transaction closes the input while the product runs
  `MME_ASSERT(a_start_busy, clk_i, rst_ni, in_valid_i && in_ready_o && start_multiply_i |=> !in_ready_o, "input still ready after start")

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);

@@ verif/tb_matrix_multiply_engine_unit.sv @@
// self-checking testbench for matrix_multiply_engine_unit (dense C = A x B, Q8.8 in, Q19.16 out)
// depends on mme_pkg and the engine top level; drives all three channels, random gaps on in/out
`timescale 1ns / 1ps

module tb_matrix_multiply_engine_unit;

  // run sizing
  localparam int unsigned RandomItems = 200;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StoreDim    = 8;

  // matrix select codes and the register index the block must ignore
  localparam logic SelA = 1'b0;
  localparam logic SelB = 1'b1;
  localparam logic [mme_pkg::CfgIdxW-1:0] RegUnknown = 2'd3;

  // receiver stall patterns
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  // one element of C as seen on the result channel
  typedef struct packed {
    logic [mme_pkg::IdxW-1:0]        row;
    logic [mme_pkg::IdxW-1:0]        col;
    logic signed [mme_pkg::ValW-1:0] value;
    logic                            last;
  } product_elem_t;

  // dut connections, all inputs known from time zero
  logic                            clk_i            = 1'b0;
  logic                            rst_ni           = 1'b0;
  logic                            cfg_valid_i      = 1'b0;
  logic                            cfg_ready_o;
  logic [mme_pkg::CfgIdxW-1:0]     cfg_index_i      = '0;
  logic [mme_pkg::DimW-1:0]        cfg_data_i       = '0;
  logic                            in_valid_i       = 1'b0;
  logic                            in_ready_o;
  logic                            matrix_select_i  = 1'b0;
  logic [mme_pkg::IdxW-1:0]        row_index_i      = '0;
  logic [mme_pkg::IdxW-1:0]        col_index_i      = '0;
  logic signed [15:0]              element_value_i  = '0;
  logic                            start_multiply_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i      = 1'b0;
  logic [mme_pkg::IdxW-1:0]        out_row_o;
  logic [mme_pkg::IdxW-1:0]        out_col_o;
  logic signed [mme_pkg::ValW-1:0] out_value_o;
  logic                            last_result_o;

  // shadow of the configuration and of both element stores
  logic [mme_pkg::DimW-1:0] rows_reg  = 4'd8;
  logic [mme_pkg::DimW-1:0] inner_reg = 4'd8;
  logic [mme_pkg::DimW-1:0] cols_reg  = 4'd8;
  logic [15:0]     a_store [StoreDim*StoreDim];
  logic [15:0]     b_store [StoreDim*StoreDim];

  product_elem_t   expected_products [$];
  int unsigned     mismatch_count = 0;
  int unsigned     stored_items   = 0;
  int unsigned     cycle_count    = 0;
  int unsigned     burst_left     = 0;

  // receiver state
  logic            hold_request = 1'b0;
  int unsigned     hold_left    = 0;
  int unsigned     mode_left    = 0;
  int unsigned     stall_phase  = 0;
  ready_mode_e     ready_mode   = READY_ALWAYS;

  matrix_multiply_engine_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .matrix_select_i  (matrix_select_i),
    .row_index_i      (row_index_i),
    .col_index_i      (col_index_i),
    .element_value_i  (element_value_i),
    .start_multiply_i (start_multiply_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o),
    .out_value_o      (out_value_o),
    .last_result_o    (last_result_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // effective dimension: zero acts as one, anything above the store size is clipped
  function automatic int unsigned fit_dim(logic [mme_pkg::DimW-1:0] r);
    if (r == '0) return 1;
    if (r > StoreDim) return StoreDim;
    return 32'(r);
  endfunction

  function automatic logic in_shape(logic sel, logic [mme_pkg::IdxW-1:0] row,
                                    logic [mme_pkg::IdxW-1:0] col);
    if (sel == SelA) return (row < fit_dim(rows_reg)) && (col < fit_dim(inner_reg));
    return (row < fit_dim(inner_reg)) && (col < fit_dim(cols_reg));
  endfunction

  // element values lean toward the Q8.8 extremes
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // store one element and, on start, queue every element of C in row-major order
  task automatic store_and_multiply(input logic sel, input logic [mme_pkg::IdxW-1:0] row,
                                    input logic [mme_pkg::IdxW-1:0] col,
                                    input logic [15:0] value, input logic start);
    int unsigned   m, k, n, i, j, t;
    longint        acc;
    product_elem_t elem;
    m = fit_dim(rows_reg);
    k = fit_dim(inner_reg);
    n = fit_dim(cols_reg);
    if (in_shape(sel, row, col)) begin
      stored_items++;
      if (sel == SelA) a_store[row*StoreDim + col] = value;
      else b_store[row*StoreDim + col] = value;
    end
    if (start) begin
      for (i = 0; i < m; i++) begin
        for (j = 0; j < n; j++) begin
          acc = 0;
          for (t = 0; t < k; t++) begin
            acc += longint'($signed(a_store[i*StoreDim + t])) *
                   longint'($signed(b_store[t*StoreDim + j]));
          end
          elem.row   = i[mme_pkg::IdxW-1:0];
          elem.col   = j[mme_pkg::IdxW-1:0];
          elem.value = acc[mme_pkg::ValW-1:0];
          elem.last  = (i == m - 1) && (j == n - 1);
          expected_products.push_back(elem);
        end
      end
    end
  endtask

  // one element transaction, with bursts of random length and random gaps between them
  task automatic send_element(input logic sel, input logic [mme_pkg::IdxW-1:0] row,
                              input logic [mme_pkg::IdxW-1:0] col,
                              input logic [15:0] value, input logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    matrix_select_i  <= sel;
    row_index_i      <= row;
    col_index_i      <= col;
    element_value_i  <= value;
    start_multiply_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    store_and_multiply(sel, row, col, value, start);
  endtask

  // sender pause: wait for every pending result, then let the engine settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one configuration transaction; valid is lowered by the caller
  task automatic write_register(input logic [mme_pkg::CfgIdxW-1:0] idx,
                                input logic [mme_pkg::DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mme_pkg::RegRowsA:    rows_reg  = data;
      mme_pkg::RegInnerDim: inner_reg = data;
      mme_pkg::RegColsB:    cols_reg  = data;
      default:     ;
    endcase
  endtask

  // all three dimensions in a randomly rotated order, optionally with a write to the unused index
  task automatic program_shape(input logic [mme_pkg::DimW-1:0] r,
                               input logic [mme_pkg::DimW-1:0] i,
                               input logic [mme_pkg::DimW-1:0] c, input logic with_unknown);
    int unsigned first, s;
    first = $urandom_range(0, 2);
    if (with_unknown) write_register(RegUnknown, mme_pkg::DimW'($urandom_range(0, 15)));
    for (s = 0; s < 3; s++) begin
      case ((first + s) % 3)
        0:       write_register(mme_pkg::RegRowsA, r);
        1:       write_register(mme_pkg::RegInnerDim, i);
        default: write_register(mme_pkg::RegColsB, c);
      endcase
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic shuffle_codes(ref int unsigned codes[$]);
    int unsigned s, pick, tmp;
    for (s = codes.size(); s > 1; s--) begin
      pick = $urandom_range(0, s - 1);
      tmp = codes[s-1];
      codes[s-1] = codes[pick];
      codes[pick] = tmp;
    end
  endtask

  // alternative dimension encodings (zero for one, 9 to 15 for eight) for the same effective size
  function automatic logic [mme_pkg::DimW-1:0] encode_dim(int unsigned d);
    if (d == 1 && $urandom_range(0, 3) == 0) return '0;
    if (d == StoreDim && $urandom_range(0, 1) == 0) return mme_pkg::DimW'($urandom_range(9, 15));
    return mme_pkg::DimW'(d);
  endfunction

  // a stray element anywhere, usually without start
  task automatic send_noise();
    send_element(logic'($urandom_range(0, 1)), mme_pkg::IdxW'($urandom_range(0, 7)),
                 mme_pkg::IdxW'($urandom_range(0, 7)), pick_value(),
                 $urandom_range(0, 39) == 0);
  endtask

  // code layout: bit 6 selects B, bits 5:0 are row*8+col
  task automatic send_code(input int unsigned code, input logic start);
    send_element(code >= StoreDim*StoreDim ? SelB : SelA,
                 mme_pkg::IdxW'((code % 64) / StoreDim),
                 mme_pkg::IdxW'(code % StoreDim), pick_value(), start);
  endtask

  // every entry written at the reset shape, which also makes later starts safe
  task automatic test_reset_full_shape();
    int unsigned codes[$];
    int unsigned s, idx;
    logic        sel;
    logic [15:0] value;
    for (s = 0; s < 2*StoreDim*StoreDim; s++) codes.push_back(s);
    shuffle_codes(codes);
    for (s = 0; s < codes.size(); s++) begin
      sel = codes[s] >= StoreDim*StoreDim;
      idx = codes[s] % 64;
      value = pick_value();
      // largest positive sum at C[0][0], most negative at C[1][1]
      if (sel == SelA && idx / StoreDim < 2) value = 16'h8000;
      if (sel == SelB && idx % StoreDim == 0) value = 16'h8000;
      if (sel == SelB && idx % StoreDim == 1) value = 16'h7FFF;
      send_element(sel, mme_pkg::IdxW'(idx / StoreDim), mme_pkg::IdxW'(idx % StoreDim), value,
                   s == codes.size() - 1);
    end
    wait_drained();
  endtask

  // extremes, dropped elements, clamped dimensions, ignored index and shape change
  task automatic test_directed_corners();
    program_shape(4'd1, 4'd1, 4'd1, 1'b0);
    send_element(SelA, 3'd0, 3'd0, 16'h8000, 1'b0);
    send_element(SelB, 3'd0, 3'd0, 16'h8000, 1'b1);
    send_element(SelA, 3'd0, 3'd0, 16'h7FFF, 1'b1);
    // start on an element that falls outside the shape
    send_element(SelA, 3'd0, 3'd1, 16'h1234, 1'b1);
    send_element(SelB, 3'd1, 3'd0, 16'hFFFF, 1'b1);
    send_element(SelB, 3'd7, 3'd7, 16'h5555, 1'b0);
    wait_drained();
    // zero acts as one, unused index must leave the shape alone
    program_shape(4'd0, 4'd0, 4'd0, 1'b1);
    send_element(SelB, 3'd0, 3'd0, 16'hFFFF, 1'b1);
    wait_drained();
    // rows above the store size clip to eight
    program_shape(4'd12, 4'd1, 4'd1, 1'b1);
    send_element(SelA, 3'd5, 3'd0, 16'h7FFF, 1'b0);
    send_element(SelA, 3'd7, 3'd0, 16'h8000, 1'b1);
    wait_drained();
    // stored entries keep their positions across a shape change
    program_shape(4'd2, 4'd8, 4'd2, 1'b0);
    send_element(SelA, 3'd1, 3'd7, 16'h8000, 1'b0);
    send_element(SelB, 3'd7, 3'd1, 16'h8000, 1'b0);
    send_element(SelA, 3'd2, 3'd0, 16'h2222, 1'b1);
    wait_drained();
  endtask

  // long receiver hold-off while start transactions keep coming
  task automatic test_backpressure();
    int unsigned s;
    program_shape(4'd2, 4'd2, 4'd2, 1'b0);
    hold_request = 1'b1;
    for (s = 0; s < 6; s++) begin
      send_element(logic'($urandom_range(0, 1)), mme_pkg::IdxW'($urandom_range(0, 1)),
                   mme_pkg::IdxW'($urandom_range(0, 1)), pick_value(), 1'b1);
    end
    wait_drained();
  endtask

  // one load sequence at the current shape, closing with a start
  task automatic run_sequence();
    int unsigned codes[$];
    int unsigned picked[$];
    int unsigned m, k, n, i, t, j, s, keep_pct;
    m = fit_dim(rows_reg);
    k = fit_dim(inner_reg);
    n = fit_dim(cols_reg);
    for (i = 0; i < m; i++)
      for (t = 0; t < k; t++) codes.push_back(i*StoreDim + t);
    for (t = 0; t < k; t++)
      for (j = 0; j < n; j++) codes.push_back(StoreDim*StoreDim + t*StoreDim + j);
    // complete sequences mostly, partial ones reuse what is already stored
    keep_pct = ($urandom_range(0, 3) == 0) ? 35 : 100;
    if (codes.size() > 32) keep_pct = 1200 / codes.size();
    for (s = 0; s < codes.size(); s++)
      if ($urandom_range(1, 100) <= keep_pct) picked.push_back(codes[s]);
    shuffle_codes(picked);
    for (s = 0; s < picked.size(); s++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_code(picked[s], s == picked.size() - 1);
    end
    if (picked.size() == 0) begin
      send_element(logic'($urandom_range(0, 1)), mme_pkg::IdxW'($urandom_range(0, 7)),
                   mme_pkg::IdxW'($urandom_range(0, 7)), pick_value(), 1'b1);
    end
  endtask

  // random shapes, mostly small, a few at full size
  task automatic test_random_shapes();
    int unsigned base, m, k, n, rounds, r;
    base = stored_items;
    while (stored_items - base < RandomItems) begin
      wait_drained();
      if ($urandom_range(0, 7) == 0) begin
        m = $urandom_range(0, 1) ? StoreDim : $urandom_range(1, StoreDim);
        k = $urandom_range(0, 1) ? StoreDim : $urandom_range(1, StoreDim);
        n = $urandom_range(0, 1) ? StoreDim : $urandom_range(1, StoreDim);
      end else begin
        m = $urandom_range(1, 4);
        k = $urandom_range(1, 4);
        n = $urandom_range(1, 4);
      end
      program_shape(encode_dim(m), encode_dim(k), encode_dim(n), $urandom_range(0, 5) == 0);
      rounds = ($urandom_range(0, 2) == 0) ? 2 : 1;
      for (r = 0; r < rounds; r++) run_sequence();
    end
  endtask

  // receiver: changing stall patterns plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    stall_phase++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS:   out_ready_i <= 1'b1;
        READY_RANDOM:   out_ready_i <= logic'($urandom_range(0, 1));
        READY_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
        default:        out_ready_i <= (stall_phase % 3 == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input product_elem_t want,
                                 input product_elem_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): exp %0d,%0d %0d last %0b, got %0d,%0d %0d last %0b",
               what, want.row, want.col, want.value, want.last,
               got.row, got.col, got.value, got.last);
    end
  endtask

  // result checker: each accepted transaction against the oldest expectation
  always @(posedge clk_i) begin : check_results
    product_elem_t want;
    product_elem_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.row   = out_row_o;
      got.col   = out_col_o;
      got.value = out_value_o;
      got.last  = last_result_o;
      if (expected_products.size() == 0) begin
        report_mismatch("no result pending", '0, got);
      end else begin
        want = expected_products.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
            got.last !== want.last) begin
          report_mismatch("field differs", want, got);
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_full_shape();
    test_directed_corners();
    test_backpressure();
    test_random_shapes();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_products.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mme_pkg.sv
hdl/mme_ram.sv
hdl/matrix_multiply_engine_unit.sv
hdl/mme_checker.sv
verif/tb_matrix_multiply_engine_unit.sv
